// File: rtl/core/shd_pkg.sv
// ----------------------------------------------------------------------------
// shd_pkg: shared host detector types and constants
// entry layout, item and register bundles, command and update codes
// ----------------------------------------------------------------------------
package shd_pkg;

   localparam int HOSTS_DEFAULT = 256;

   // input command codes
   localparam logic [1:0] CMD_PACKET    = 2'd0;
   localparam logic [1:0] CMD_SWEEP     = 2'd1;
   localparam logic [1:0] CMD_CLR_HOST  = 2'd2;
   localparam logic [1:0] CMD_CLR_ALL   = 2'd3;

   // entry update codes
   localparam logic [1:0] UOP_PACKET = 2'd0;
   localparam logic [1:0] UOP_AGE    = 2'd1;
   localparam logic [1:0] UOP_CLEAR  = 2'd2;
   localparam logic [1:0] UOP_ZERO   = 2'd3;

   // register indexes and reset values
   localparam logic [1:0] REG_CONTROL_TIME = 2'd0;
   localparam logic [1:0] REG_ID_WINDOW    = 2'd1;
   localparam logic [1:0] REG_LINEAR_WIN   = 2'd2;
   localparam logic [1:0] REG_JUMP_LIMIT   = 2'd3;

   localparam logic [31:0] CONTROL_TIME_RESET = 32'd300;
   localparam logic [31:0] ID_WINDOW_RESET    = 32'd10;
   localparam logic [15:0] LINEAR_WIN_RESET   = 16'd500;
   localparam logic [7:0]  JUMP_LIMIT_RESET   = 8'd10;

   // host flag bits
   localparam int         FLAG_TTL_BIT = 0;
   localparam int         FLAG_ID_BIT  = 1;
   localparam logic [1:0] BOTH_FLAGS   = 2'b11;

   localparam logic [15:0] ID_MAX = 16'hFFFF;

   localparam logic [7:0] USUAL_TTLS [4] = '{8'd32, 8'd64, 8'd128, 8'd255};

   typedef struct packed {
      logic [1:0]  flags;
      logic [15:0] last_id;
      logic [8:0]  jump_cnt;
      logic [31:0] jump_start;
      logic [31:0] shared_since;
   } entry_type;

   typedef struct packed {
      logic [15:0] ip_id;
      logic [7:0]  ttl;
      logic        is_tcp;
      logic        from_lan;
      logic [31:0] now_sec;
   } item_type;

   typedef struct packed {
      logic [31:0] control_time;
      logic [31:0] id_check_window;
      logic [15:0] linear_window;
      logic [7:0]  jump_limit;
   } cfg_type;

endpackage

// File: rtl/core/shared_host_detector.sv
// ----------------------------------------------------------------------------
// shared_host_detector: per-host detector of lan hosts sharing a connection
// host entry table with one shared update unit under a small sequencer
// ----------------------------------------------------------------------------
// a packet or clear-host item has its entry read at the edge that accepts
// the item, updated and written back at the next edge, and the result
// strobe is high in the cycle after that, in which a new item may already
// be accepted. sweep and clear-all items walk the whole table through the
// single entry update unit, one entry per cycle, with the strobe high once
// the last entry is written back. after reset the table is zeroed by the
// same walk, which keeps busy high until its last entry is written;
// register writes are taken throughout.
// every item gives exactly one result, shown for one cycle on rsp_strobe,
// and the receiver cannot hold it off. the result shows the addressed host
// entry after the item; the entry used is req_host modulo HOSTS.
// ----------------------------------------------------------------------------
module shared_host_detector
   import shd_pkg::*;
#(
   parameter int HOSTS = HOSTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   // item channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_host,
   input  logic [15:0] req_ip_id,
   input  logic [7:0]  req_ttl,
   input  logic        req_is_tcp,
   input  logic        req_from_lan,
   input  logic [31:0] req_now_sec,

   // result channel
   output logic        rsp_strobe,
   output logic        rsp_shared,
   output logic        rsp_ttl_odd,
   output logic        rsp_id_odd,
   output logic [8:0]  rsp_jump_count,

   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IDX_W      = $clog2(HOSTS);
   localparam int HOST_CODES = 256;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOSTS - 1);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ENTRY = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   // ------------------------------------------------------------------------
   // host index map: req_host modulo HOSTS as a constant table
   // ------------------------------------------------------------------------
   logic [IDX_W-1:0] host_map [HOST_CODES];

   for (genvar i = 0; i < HOST_CODES; i++) begin : g_host_map
      localparam logic [IDX_W-1:0] MAPPED = IDX_W'(i % HOSTS);
      assign host_map[i] = MAPPED;
   end

   // ------------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------------
   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       csr_write;
   logic [1:0] csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_CONTROL_TIME: cfg_in.control_time    = pwdata;
            REG_ID_WINDOW:    cfg_in.id_check_window = pwdata;
            REG_LINEAR_WIN:   cfg_in.linear_window   = pwdata[15:0];
            REG_JUMP_LIMIT:   cfg_in.jump_limit      = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_time    <= CONTROL_TIME_RESET;
         cfg_ff.id_check_window <= ID_WINDOW_RESET;
         cfg_ff.linear_window   <= LINEAR_WIN_RESET;
         cfg_ff.jump_limit      <= JUMP_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_CONTROL_TIME: prdata = cfg_ff.control_time;
         REG_ID_WINDOW:    prdata = cfg_ff.id_check_window;
         REG_LINEAR_WIN:   prdata = {16'd0, cfg_ff.linear_window};
         REG_JUMP_LIMIT:   prdata = {24'd0, cfg_ff.jump_limit};
         default:          prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   logic [1:0]       state_ff, state_in;
   logic [1:0]       uop_ff, uop_in;
   logic             walk_rsp_ff, walk_rsp_in;   // walk ends in a result
   logic [IDX_W-1:0] scan_ff, scan_in;           // walk read pointer
   logic             wb_valid_ff, wb_valid_in;   // walk write-back pending
   logic [IDX_W-1:0] wb_addr_ff, wb_addr_in;
   logic             strobe_ff, strobe_in;

   // item payload, held while the item is at work
   logic [IDX_W-1:0] host_ff, host_in;
   item_type         item_ff, item_in;

   logic             accept;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        rd_entry;
   entry_type        upd_entry;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      uop_in      = uop_ff;
      walk_rsp_in = walk_rsp_ff;
      scan_in     = scan_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = wb_addr_ff;
      strobe_in   = 1'b0;
      host_in     = host_ff;
      item_in     = item_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               host_in       = host_map[req_host];
               item_in.ip_id    = req_ip_id;
               item_in.ttl      = req_ttl;
               item_in.is_tcp   = req_is_tcp;
               item_in.from_lan = req_from_lan;
               item_in.now_sec  = req_now_sec;
               scan_in       = '0;
               walk_rsp_in   = 1'b1;
               unique case (req_cmd)
                  CMD_PACKET: begin
                     uop_in   = UOP_PACKET;
                     state_in = ST_ENTRY;
                  end
                  CMD_CLR_HOST: begin
                     uop_in   = UOP_CLEAR;
                     state_in = ST_ENTRY;
                  end
                  CMD_SWEEP: begin
                     uop_in   = UOP_AGE;
                     state_in = ST_SCAN;
                  end
                  CMD_CLR_ALL: begin
                     uop_in   = UOP_CLEAR;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ENTRY: begin
            // entry read at the accept edge is written back here
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            wb_valid_in = 1'b1;
            wb_addr_in  = scan_ff;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // last write-back of the walk
            strobe_in = walk_rsp_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // zeroing walk straight out of reset
         state_ff    <= ST_SCAN;
         uop_ff      <= UOP_ZERO;
         walk_rsp_ff <= 1'b0;
         scan_ff     <= '0;
         wb_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         uop_ff      <= uop_in;
         walk_rsp_ff <= walk_rsp_in;
         scan_ff     <= scan_in;
         wb_valid_ff <= wb_valid_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      host_ff    <= host_in;
      item_ff    <= item_in;
   end

   // ------------------------------------------------------------------------
   // entry store and update unit
   // ------------------------------------------------------------------------
   always_comb begin
      unique case (state_ff)
         ST_IDLE:  rd_addr = host_map[req_host];
         ST_SCAN:  rd_addr = scan_ff;
         default:  rd_addr = host_ff;
      endcase
   end

   assign wr_en   = (state_ff == ST_ENTRY) || wb_valid_ff;
   assign wr_addr = (state_ff == ST_ENTRY) ? host_ff : wb_addr_ff;

   shd_entry_mem #(
      .DEPTH   (HOSTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (upd_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   shd_entry_unit u_unit (
      .uop  (uop_ff),
      .cur  (rd_entry),
      .item (item_ff),
      .cfg  (cfg_ff),
      .nxt  (upd_entry)
   );

   // ------------------------------------------------------------------------
   // result: capture the addressed entry as it is written back
   // ------------------------------------------------------------------------
   logic       res_shared_ff, res_shared_in;
   logic       res_ttl_ff, res_ttl_in;
   logic       res_id_ff, res_id_in;
   logic [8:0] res_cnt_ff, res_cnt_in;
   logic       capture;

   assign capture = wr_en && (wr_addr == host_ff);

   always_comb begin
      res_shared_in = res_shared_ff;
      res_ttl_in    = res_ttl_ff;
      res_id_in     = res_id_ff;
      res_cnt_in    = res_cnt_ff;
      if (capture) begin
         res_shared_in = (upd_entry.flags == BOTH_FLAGS);
         res_ttl_in    = upd_entry.flags[FLAG_TTL_BIT];
         res_id_in     = upd_entry.flags[FLAG_ID_BIT];
         res_cnt_in    = upd_entry.jump_cnt;
      end
   end

   always_ff @(posedge clock) begin
      res_shared_ff <= res_shared_in;
      res_ttl_ff    <= res_ttl_in;
      res_id_ff     <= res_id_in;
      res_cnt_ff    <= res_cnt_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_shared     = res_shared_ff;
   assign rsp_ttl_odd    = res_ttl_ff;
   assign rsp_id_odd     = res_id_ff;
   assign rsp_jump_count = res_cnt_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   // single-entry items give their result once the entry is written back
   a_entry_latency: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == CMD_PACKET || req_cmd == CMD_CLR_HOST))
         |=> ##1 rsp_strobe)
      else $error("single-entry item result missing");

   // walk write-back never hits the entry being read in the same cycle
   a_walk_no_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && wb_valid_ff) |-> (wb_addr_ff != scan_ff))
      else $error("walk read and write-back address clash");

   // result is a one-cycle pulse and the block is idle when it shows
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // the zeroing walk after reset never raises a result
   a_no_init_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !walk_rsp_ff) |=> !rsp_strobe)
      else $error("result raised by table zeroing");

endmodule

// File: rtl/core/shd_entry_mem.sv
// ----------------------------------------------------------------------------
// shd_entry_mem: host entry store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module shd_entry_mem
   import shd_pkg::*;
#(
   parameter int DEPTH = HOSTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/shd_entry_unit.sv
// ----------------------------------------------------------------------------
// shd_entry_unit: host entry update unit
// id linearity and ttl checks, ageing and clearing of one entry
// ----------------------------------------------------------------------------
module shd_entry_unit
   import shd_pkg::*;
(
   input  logic [1:0] uop,
   input  entry_type  cur,
   input  item_type   item,
   input  cfg_type    cfg,
   output entry_type  nxt
);

   logic        a_lt_b;
   logic [15:0] id_lo;
   logic [15:0] id_hi;
   logic [16:0] lo_sum;
   logic [16:0] hi_sum;
   logic        linear;
   logic [8:0]  cnt_inc;
   logic        jump_over;
   logic        ttl_usual;
   logic [31:0] shared_age;
   logic [31:0] jump_age;

   // id gap check with 16-bit wrap
   always_comb begin
      a_lt_b = cur.last_id < item.ip_id;
      id_lo  = a_lt_b ? cur.last_id : item.ip_id;
      id_hi  = a_lt_b ? item.ip_id : cur.last_id;
      lo_sum = {1'b0, id_lo} + {1'b0, cfg.linear_window};
      hi_sum = {1'b0, id_hi} + {1'b0, cfg.linear_window};
      linear = (cur.last_id == item.ip_id) || (lo_sum > {1'b0, ID_MAX})
            || (lo_sum > {1'b0, id_hi}) || (hi_sum[16] && (hi_sum[15:0] > id_lo));
   end

   always_comb begin
      ttl_usual = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (item.ttl == USUAL_TTLS[i]) begin
            ttl_usual = 1'b1;
         end
      end
   end

   assign cnt_inc    = cur.jump_cnt + 9'd1;
   assign jump_over  = cnt_inc > {1'b0, cfg.jump_limit};
   assign shared_age = item.now_sec - cur.shared_since;
   assign jump_age   = item.now_sec - cur.jump_start;

   always_comb begin
      nxt = cur;
      unique case (uop)
         UOP_PACKET: begin
            if (item.is_tcp && item.from_lan && cur.flags != BOTH_FLAGS) begin
               if (!cur.flags[FLAG_ID_BIT]) begin
                  if (cur.last_id != '0 && !linear) begin
                     if (jump_over) begin
                        nxt.flags[FLAG_ID_BIT] = 1'b1;
                        nxt.last_id            = '0;
                        nxt.jump_cnt           = '0;
                        nxt.jump_start         = '0;
                     end else begin
                        nxt.last_id  = item.ip_id;
                        nxt.jump_cnt = cnt_inc;
                        if (cnt_inc == 9'd1) begin
                           nxt.jump_start = item.now_sec;
                        end
                     end
                  end else begin
                     nxt.last_id = item.ip_id;
                  end
               end
               if (!cur.flags[FLAG_TTL_BIT] && !ttl_usual) begin
                  nxt.flags[FLAG_TTL_BIT] = 1'b1;
               end
               if (nxt.flags == BOTH_FLAGS) begin
                  nxt.shared_since = item.now_sec;
               end
            end
         end
         UOP_AGE: begin
            if (cur.flags == BOTH_FLAGS) begin
               if (cfg.control_time != '0 && shared_age > cfg.control_time) begin
                  nxt.flags        = '0;
                  nxt.shared_since = '0;
               end
            end else if (cur.jump_cnt != '0 && jump_age > cfg.id_check_window) begin
               nxt.jump_cnt   = '0;
               nxt.jump_start = '0;
            end
         end
         UOP_CLEAR: begin
            nxt.flags        = '0;
            nxt.shared_since = '0;
         end
         UOP_ZERO: begin
            nxt = '0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

endmodule

// File: tb/sv/tb_shared_host_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shared_host_detector: self-checking bench for the shared host detector
// a short table of directed items and register writes, then random phases
// under several register settings; every result is checked field by field
// against a local model of the host table or a value typed in the table
// ----------------------------------------------------------------------------
module tb_shared_host_detector;
   import shd_pkg::*;

   localparam int HOSTS       = HOSTS_DEFAULT;
   localparam int PHASES      = 5;
   localparam int PHASE_ITEMS = 195;

   // kinds of row in the directed table
   localparam bit ROW_ITEM  = 1'b0;
   localparam bit ROW_WRITE = 1'b1;
   // where the expected result of a row comes from
   localparam bit EXP_MODEL = 1'b0;
   localparam bit EXP_TYPED = 1'b1;

   typedef struct packed {
      logic       shared;
      logic       ttl_odd;
      logic       id_odd;
      logic [8:0] jump_count;
   } host_view_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] host;
      item_type   pkt;
   } host_item_type;

   typedef struct packed {
      bit            kind;
      logic [1:0]    reg_idx;
      logic [31:0]   reg_val;
      logic [1:0]    cmd;
      logic [7:0]    host;
      logic [15:0]   ip_id;
      logic [7:0]    ttl;
      logic          is_tcp;
      logic          from_lan;
      logic [31:0]   now_sec;
      bit            typed;
      host_view_type want;
   } dir_row_type;

   localparam host_view_type NO_FLAGS = '0;
   localparam host_view_type ONLY_TTL = '{1'b0, 1'b1, 1'b0, 9'd0};
   localparam host_view_type ONLY_ID  = '{1'b0, 1'b0, 1'b1, 9'd0};
   localparam host_view_type ALL_SET  = '{1'b1, 1'b1, 1'b1, 9'd0};

   // directed table, starting from the reset register values
   localparam dir_row_type DIRECTED_ROWS [32] = '{
      // first ids are only recorded, even an id of zero
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd0, 16'h0000, 8'd64, 1'b1, 1'b1,
        32'd0, EXP_TYPED, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd255, 16'hFFFF, 8'd255, 1'b1, 1'b1,
        32'd1, EXP_TYPED, NO_FLAGS},
      // wrap from the top of the id range back to zero
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd255, 16'h0000, 8'd32, 1'b1, 1'b1,
        32'd2, EXP_MODEL, NO_FLAGS},
      // odd ttl of zero
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd1, 16'h1234, 8'd0, 1'b1, 1'b1,
        32'd3, EXP_TYPED, ONLY_TTL},
      // not tcp, then not from the lan: nothing changes
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd2, 16'h0005, 8'd7, 1'b0, 1'b1,
        32'd4, EXP_TYPED, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd2, 16'h0005, 8'd7, 1'b1, 1'b0,
        32'd4, EXP_TYPED, NO_FLAGS},
      // one jump, then sweeps either side of the id check window
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd2, 16'h0005, 8'd128, 1'b1, 1'b1,
        32'd4, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd2, 16'h9C40, 8'd128, 1'b1, 1'b1,
        32'd5, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd2, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd15, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd2, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd16, EXP_MODEL, NO_FLAGS},
      // a single jump exceeds a limit of zero
      '{ROW_WRITE, REG_JUMP_LIMIT, 32'd0, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd3, 16'd100, 8'd64, 1'b1, 1'b1,
        32'd1000, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd3, 16'd5000, 8'd64, 1'b1, 1'b1,
        32'd1001, EXP_TYPED, ONLY_ID},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd3, 16'd7, 8'd1, 1'b1, 1'b1,
        32'd1002, EXP_TYPED, ALL_SET},
      // packet to a shared host is ignored
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd3, 16'd9, 8'd64, 1'b1, 1'b1,
        32'd1003, EXP_MODEL, NO_FLAGS},
      // shared mark held at exactly control_time, dropped one second later
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd3, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd1302, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd3, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd1303, EXP_MODEL, NO_FLAGS},
      // control_time of zero holds the mark forever
      '{ROW_WRITE, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd4, 16'd10, 8'd200, 1'b1, 1'b1,
        32'd5, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd4, 16'h9C40, 8'd200, 1'b1, 1'b1,
        32'd6, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd4, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'hFFFF_FFFF, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_CLR_HOST, 8'd4, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_TYPED, NO_FLAGS},
      // zero linear window: any change of id is a jump
      '{ROW_WRITE, REG_LINEAR_WIN, 32'd0, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_WRITE, REG_JUMP_LIMIT, 32'd255, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd5, 16'd7, 8'd64, 1'b1, 1'b1,
        32'd50, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd5, 16'd8, 8'd64, 1'b1, 1'b1,
        32'd51, EXP_MODEL, NO_FLAGS},
      // zero id check window drops the count on the next sweep
      '{ROW_WRITE, REG_ID_WINDOW, 32'd0, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_SWEEP, 8'd5, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd52, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_CLR_ALL, 8'd1, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_TYPED, NO_FLAGS},
      // full linear window: everything is linear
      '{ROW_WRITE, REG_LINEAR_WIN, 32'd65535, CMD_PACKET, 8'd0, 16'h0000, 8'd0, 1'b0, 1'b0,
        32'd0, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd6, 16'h0001, 8'd64, 1'b1, 1'b1,
        32'd60, EXP_MODEL, NO_FLAGS},
      '{ROW_ITEM, REG_CONTROL_TIME, 32'd0, CMD_PACKET, 8'd6, 16'hFFFF, 8'd64, 1'b1, 1'b1,
        32'd61, EXP_MODEL, NO_FLAGS}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_cmd = CMD_PACKET;
   logic [7:0]  req_host = '0;
   logic [15:0] req_ip_id = '0;
   logic [7:0]  req_ttl = '0;
   logic        req_is_tcp = 1'b0;
   logic        req_from_lan = 1'b0;
   logic [31:0] req_now_sec = '0;
   logic        rsp_strobe;
   logic        rsp_shared;
   logic        rsp_ttl_odd;
   logic        rsp_id_odd;
   logic [8:0]  rsp_jump_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // model of the host table and of the registers
   logic [1:0]  flag_tbl [HOSTS];
   logic [15:0] last_id_tbl [HOSTS];
   logic [8:0]  jump_tbl [HOSTS];
   logic [31:0] jump_since_tbl [HOSTS];
   logic [31:0] shared_since_tbl [HOSTS];
   cfg_type     cfg;

   host_view_type expected_views [$];
   int            mismatches = 0;

   always #5 clock = ~clock;

   shared_host_detector DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_host       (req_host),
      .req_ip_id      (req_ip_id),
      .req_ttl        (req_ttl),
      .req_is_tcp     (req_is_tcp),
      .req_from_lan   (req_from_lan),
      .req_now_sec    (req_now_sec),
      .rsp_strobe     (rsp_strobe),
      .rsp_shared     (rsp_shared),
      .rsp_ttl_odd    (rsp_ttl_odd),
      .rsp_id_odd     (rsp_id_odd),
      .rsp_jump_count (rsp_jump_count),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // id step counts as linear within the window, with the 16-bit wrap rules
   function automatic bit id_step_linear(input logic [15:0] prev, input logic [15:0] id);
      int unsigned lo;
      int unsigned hi;
      int unsigned win;
      win = cfg.linear_window;
      if (prev == id) return 1'b1;
      lo = (prev < id) ? prev : id;
      hi = (prev < id) ? id : prev;
      if (lo + win > ID_MAX) return 1'b1;
      if (lo + win > hi) return 1'b1;
      // the window reaching past the top wraps round to low ids
      if (hi + win > ID_MAX && ((hi + win) & ID_MAX) > lo) return 1'b1;
      return 1'b0;
   endfunction

   // applies one item to the modelled table and returns the addressed entry
   function automatic host_view_type apply_host_item(input host_item_type it);
      int            h;
      bit            usual;
      host_view_type view;
      h = int'(it.host) % HOSTS;
      case (it.cmd)
         CMD_PACKET: begin
            if (it.pkt.is_tcp && it.pkt.from_lan && flag_tbl[h] != BOTH_FLAGS) begin
               // id check, skipped once the id flag is up
               if (!flag_tbl[h][FLAG_ID_BIT]) begin
                  if (last_id_tbl[h] != '0 && !id_step_linear(last_id_tbl[h], it.pkt.ip_id))
                  begin
                     jump_tbl[h] = jump_tbl[h] + 9'd1;
                     if (jump_tbl[h] > cfg.jump_limit) begin
                        flag_tbl[h][FLAG_ID_BIT] = 1'b1;
                        last_id_tbl[h]    = '0;
                        jump_tbl[h]       = '0;
                        jump_since_tbl[h] = '0;
                     end else begin
                        last_id_tbl[h] = it.pkt.ip_id;
                        if (jump_tbl[h] == 9'd1) jump_since_tbl[h] = it.pkt.now_sec;
                     end
                  end else begin
                     last_id_tbl[h] = it.pkt.ip_id;
                  end
               end
               // ttl check
               usual = 1'b0;
               foreach (USUAL_TTLS[k])
                  if (it.pkt.ttl == USUAL_TTLS[k]) usual = 1'b1;
               if (!usual) flag_tbl[h][FLAG_TTL_BIT] = 1'b1;
               if (flag_tbl[h] == BOTH_FLAGS) shared_since_tbl[h] = it.pkt.now_sec;
            end
         end
         CMD_SWEEP: begin
            for (int e = 0; e < HOSTS; e++) begin
               if (flag_tbl[e] == BOTH_FLAGS) begin
                  if (cfg.control_time != '0 &&
                      (it.pkt.now_sec - shared_since_tbl[e]) > cfg.control_time) begin
                     flag_tbl[e]         = '0;
                     shared_since_tbl[e] = '0;
                  end
               end else if (jump_tbl[e] != '0) begin
                  if ((it.pkt.now_sec - jump_since_tbl[e]) > cfg.id_check_window) begin
                     jump_tbl[e]       = '0;
                     jump_since_tbl[e] = '0;
                  end
               end
            end
         end
         CMD_CLR_HOST: begin
            flag_tbl[h]         = '0;
            shared_since_tbl[h] = '0;
         end
         default: begin
            for (int e = 0; e < HOSTS; e++) begin
               flag_tbl[e]         = '0;
               shared_since_tbl[e] = '0;
            end
         end
      endcase
      view.shared     = (flag_tbl[h] == BOTH_FLAGS);
      view.ttl_odd    = flag_tbl[h][FLAG_TTL_BIT];
      view.id_odd     = flag_tbl[h][FLAG_ID_BIT];
      view.jump_count = jump_tbl[h];
      return view;
   endfunction

   // mostly no gap or a short one, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // drive one item and wait for it to be taken; the expectation is queued on acceptance
   task automatic send_item(input host_item_type it, input bit typed,
                            input host_view_type want);
      host_view_type view;
      @(negedge clock);
      start        <= 1'b1;
      req_cmd      <= it.cmd;
      req_host     <= it.host;
      req_ip_id    <= it.pkt.ip_id;
      req_ttl      <= it.pkt.ttl;
      req_is_tcp   <= it.pkt.is_tcp;
      req_from_lan <= it.pkt.from_lan;
      req_now_sec  <= it.pkt.now_sec;
      @(posedge clock);
      while (busy) @(posedge clock);
      view = apply_host_item(it);
      expected_views.push_back(typed ? want : view);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // lower start, then wait until every expected result is in and the block is idle
   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (expected_views.size() != 0 || busy) @(posedge clock);
   endtask

   // one register transfer: setup cycle, then access cycle until pready
   task automatic csr_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] data,
                            output logic [31:0] rd);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // write a register while idle, mirror it in the model and check the read back
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      logic [31:0] rd;
      logic [31:0] want;
      wait_drained();
      csr_cycle(1'b1, idx, val, rd);
      csr_cycle(1'b0, idx, '0, rd);
      case (idx)
         REG_CONTROL_TIME: begin
            cfg.control_time = val;
            want = val;
         end
         REG_ID_WINDOW: begin
            cfg.id_check_window = val;
            want = val;
         end
         REG_LINEAR_WIN: begin
            cfg.linear_window = val[15:0];
            want = {16'd0, val[15:0]};
         end
         default: begin
            cfg.jump_limit = val[7:0];
            want = {24'd0, val[7:0]};
         end
      endcase
      if (rd !== want) report_mismatch("register read back", rd, want);
   endtask

   // result checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin
      host_view_type want;
      if (!reset && rsp_strobe) begin
         if (expected_views.size() == 0) begin
            report_mismatch("result with none expected", 32'd1, 32'd0);
         end else begin
            want = expected_views.pop_front();
            if (rsp_shared !== want.shared)
               report_mismatch("shared", rsp_shared, want.shared);
            if (rsp_ttl_odd !== want.ttl_odd)
               report_mismatch("ttl_odd", rsp_ttl_odd, want.ttl_odd);
            if (rsp_id_odd !== want.id_odd)
               report_mismatch("id_odd", rsp_id_odd, want.id_odd);
            if (rsp_jump_count !== want.jump_count)
               report_mismatch("jump_count", rsp_jump_count, want.jump_count);
         end
      end
   end

   initial begin
      dir_row_type   row;
      host_item_type it;
      logic [15:0]   sent_id [HOSTS];
      logic [31:0]   cur_time;
      logic [7:0]    pool_base;
      logic [7:0]    h;
      int            pool_size;
      int            r;
      bit            no_idle;

      // model starts from the reset state
      cfg.control_time    = CONTROL_TIME_RESET;
      cfg.id_check_window = ID_WINDOW_RESET;
      cfg.linear_window   = LINEAR_WIN_RESET;
      cfg.jump_limit      = JUMP_LIMIT_RESET;
      for (int e = 0; e < HOSTS; e++) begin
         flag_tbl[e]         = '0;
         last_id_tbl[e]      = '0;
         jump_tbl[e]         = '0;
         jump_since_tbl[e]   = '0;
         shared_since_tbl[e] = '0;
         sent_id[e]          = '0;
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; the clearing walk after reset is covered by the busy handshake
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            write_reg(row.reg_idx, row.reg_val);
         end else begin
            it.cmd          = row.cmd;
            it.host         = row.host;
            it.pkt.ip_id    = row.ip_id;
            it.pkt.ttl      = row.ttl;
            it.pkt.is_tcp   = row.is_tcp;
            it.pkt.from_lan = row.from_lan;
            it.pkt.now_sec  = row.now_sec;
            send_item(it, row.typed, row.want);
            hold_off(gap_len());
         end
      end

      // random phases, each under its own register setting
      cur_time = $urandom;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               // lowest values throughout
               write_reg(REG_CONTROL_TIME, 32'd0);
               write_reg(REG_ID_WINDOW, 32'd0);
               write_reg(REG_LINEAR_WIN, 32'd0);
               write_reg(REG_JUMP_LIMIT, 32'd0);
            end
            1: begin
               // highest values throughout
               write_reg(REG_CONTROL_TIME, 32'hFFFF_FFFF);
               write_reg(REG_ID_WINDOW, 32'hFFFF_FFFF);
               write_reg(REG_LINEAR_WIN, 32'd65535);
               write_reg(REG_JUMP_LIMIT, 32'd255);
            end
            default: begin
               // short timers and small limits so that flags come and go
               write_reg(REG_CONTROL_TIME, $urandom_range(1, 60));
               write_reg(REG_ID_WINDOW, $urandom_range(0, 20));
               write_reg(REG_LINEAR_WIN, $urandom_range(0, 2000));
               write_reg(REG_JUMP_LIMIT, $urandom_range(0, 8));
            end
         endcase
         no_idle   = (phase == 3);
         pool_base = 8'($urandom);
         pool_size = $urandom_range(2, 8);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender now and then lets the block run dry
            if ($urandom_range(0, 99) < 2) wait_drained();

            r = $urandom_range(0, 99);
            if (r < 84)      it.cmd = CMD_PACKET;
            else if (r < 92) it.cmd = CMD_SWEEP;
            else if (r < 97) it.cmd = CMD_CLR_HOST;
            else             it.cmd = CMD_CLR_ALL;

            // a few hosts get most of the traffic, so their entries evolve
            if ($urandom_range(0, 9) == 0) h = 8'($urandom);
            else h = pool_base + 8'($urandom_range(0, pool_size - 1));
            it.host = h;

            // ids mostly step from the last one sent, around the window edge
            r = $urandom_range(0, 99);
            if (r < 60)
               it.pkt.ip_id = sent_id[h] +
                              16'($urandom_range(0, 2 * int'(cfg.linear_window) + 8));
            else if (r < 92) it.pkt.ip_id = 16'($urandom);
            else if (r < 96) it.pkt.ip_id = 16'h0000;
            else             it.pkt.ip_id = ID_MAX;
            sent_id[h] = it.pkt.ip_id;

            if ($urandom_range(0, 99) < 80) it.pkt.ttl = USUAL_TTLS[$urandom_range(0, 3)];
            else it.pkt.ttl = 8'($urandom);

            // mostly lan tcp, the rest noise
            if ($urandom_range(0, 99) < 90) begin
               it.pkt.is_tcp   = 1'b1;
               it.pkt.from_lan = 1'b1;
            end else begin
               it.pkt.is_tcp   = 1'($urandom);
               it.pkt.from_lan = 1'($urandom);
            end

            // time creeps on, jumps before some sweeps and now and then anywhere
            if ($urandom_range(0, 99) < 3) cur_time = $urandom;
            else cur_time = cur_time + $urandom_range(0, 3);
            if (it.cmd == CMD_SWEEP && $urandom_range(0, 9) < 3)
               cur_time = cur_time + $urandom_range(0, 80);
            it.pkt.now_sec = cur_time;

            send_item(it, EXP_MODEL, NO_FLAGS);
            if (!no_idle) hold_off(gap_len());
         end
      end

      wait_drained();
      repeat (HOSTS + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
